// File: rtl/rtp_hp_pkg.sv
// rtp_hp_pkg: shared types and constants for the rtp header parser
// no dependencies; used by every rtl module
package rtp_hp_pkg;

    localparam int unsigned CNT_W = 16;
    localparam logic [CNT_W-1:0] MAX_PACKET_BYTES = 16'd65535;
    localparam logic [CNT_W-1:0] FIXED_LEN = 16'd12;
    localparam logic [1:0] RTP_VERSION = 2'd2;

    // wide enough for fixed header, csrc list and largest extension
    localparam int unsigned OFS_W = 19;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SHORT  = 2'd1,
        ST_BADVER = 2'd2
    } t_status;

    // header view after the current byte has been taken in
    typedef struct packed {
        logic [CNT_W-1:0] byte_count;
        logic [7:0]       first_byte;
        logic [7:0]       second_byte;
        logic [15:0]      sequence_word;
        logic [31:0]      timestamp_word;
        logic [31:0]      source_word;
        logic [15:0]      extension_words;
    } t_hdr;

    typedef struct packed {
        t_status     status;
        logic [1:0]  version;
        logic        padding_flag;
        logic        extension_flag;
        logic [3:0]  csrc_count;
        logic        marker_flag;
        logic [6:0]  payload_type;
        logic [15:0] sequence_number;
        logic [31:0] timestamp;
        logic [31:0] ssrc;
        logic [15:0] payload_offset;
    } t_result;

endpackage

// File: rtl/rtp_hp_if.sv
// rtp_hp_in_if / rtp_hp_out_if: valid/ready channels of the rtp header parser
// no dependencies; status is carried as plain logic [1:0]
interface rtp_hp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source(output valid, output data_byte, output last_byte, input ready);
    modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface rtp_hp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [1:0]  version;
    logic        padding_flag;
    logic        extension_flag;
    logic [3:0]  csrc_count;
    logic        marker_flag;
    logic [6:0]  payload_type;
    logic [15:0] sequence_number;
    logic [31:0] timestamp;
    logic [31:0] ssrc;
    logic [15:0] payload_offset;

    modport source(
        output valid, input ready,
        output status, output version, output padding_flag, output extension_flag,
        output csrc_count, output marker_flag, output payload_type,
        output sequence_number, output timestamp, output ssrc, output payload_offset
    );
    modport sink(
        input valid, output ready,
        input status, input version, input padding_flag, input extension_flag,
        input csrc_count, input marker_flag, input payload_type,
        input sequence_number, input timestamp, input ssrc, input payload_offset
    );
endinterface

// File: rtl/rtp_hp_capture.sv
// rtp_hp_capture: byte counter and fixed header / extension length capture
// depends on rtp_hp_pkg
module rtp_hp_capture (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output rtp_hp_pkg::t_hdr   o_view
);
    import rtp_hp_pkg::*;

    t_hdr             r_hdr;
    t_hdr             n_view;
    logic [CNT_W-1:0] list_end;
    logic [CNT_W-1:0] pos;

    assign pos      = r_hdr.byte_count;
    assign list_end = FIXED_LEN + CNT_W'({r_hdr.first_byte[3:0], 2'b00});

    always_comb begin
        n_view = r_hdr;
        if (i_accept && (pos < MAX_PACKET_BYTES)) begin
            n_view.byte_count = pos + 1'b1;
            if (pos == 16'd0) begin
                n_view.first_byte = i_data_byte;
            end else if (pos == 16'd1) begin
                n_view.second_byte = i_data_byte;
            end else if (pos < 16'd4) begin
                n_view.sequence_word = {r_hdr.sequence_word[7:0], i_data_byte};
            end else if (pos < 16'd8) begin
                n_view.timestamp_word = {r_hdr.timestamp_word[23:0], i_data_byte};
            end else if (pos < FIXED_LEN) begin
                n_view.source_word = {r_hdr.source_word[23:0], i_data_byte};
            end else if ((pos == list_end + 16'd2) || (pos == list_end + 16'd3)) begin
                n_view.extension_words = {r_hdr.extension_words[7:0], i_data_byte};
            end
        end
    end

    assign o_view = n_view;

    // all state clears once the final byte is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr <= '0;
        end else if (i_accept && i_last_byte) begin
            r_hdr <= '0;
        end else begin
            r_hdr <= n_view;
        end
    end

endmodule

// File: rtl/rtp_hp_check.sv
// rtp_hp_check: length and version checks, payload offset and result fields
// depends on rtp_hp_pkg
module rtp_hp_check (
    input  rtp_hp_pkg::t_hdr    i_view,
    output rtp_hp_pkg::t_result o_result
);
    import rtp_hp_pkg::*;

    logic [OFS_W-1:0] len;
    logic [OFS_W-1:0] list_end;
    logic [OFS_W-1:0] ext_start;
    logic [OFS_W-1:0] ext_end;
    logic [OFS_W-1:0] offset;
    logic [1:0]       ver;
    logic             has_ext;
    t_status          status;

    assign len       = OFS_W'(i_view.byte_count);
    assign ver       = i_view.first_byte[7:6];
    assign has_ext   = i_view.first_byte[4];
    assign list_end  = OFS_W'(FIXED_LEN) + OFS_W'({i_view.first_byte[3:0], 2'b00});
    assign ext_start = list_end + OFS_W'(4);
    assign ext_end   = ext_start + OFS_W'({i_view.extension_words, 2'b00});
    assign offset    = has_ext ? ext_end : list_end;

    always_comb begin
        if (len < OFS_W'(FIXED_LEN)) begin
            status = ST_SHORT;
        end else if (ver != RTP_VERSION) begin
            status = ST_BADVER;
        end else if (len < list_end) begin
            status = ST_SHORT;
        end else if (has_ext && (len < ext_start)) begin
            status = ST_SHORT;
        end else if (has_ext && (len < ext_end)) begin
            status = ST_SHORT;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_result        = '0;
        o_result.status = status;
        if (status == ST_BADVER) begin
            o_result.version = ver;
        end
        if (status == ST_OK) begin
            o_result.version         = ver;
            o_result.padding_flag    = i_view.first_byte[5];
            o_result.extension_flag  = has_ext;
            o_result.csrc_count      = i_view.first_byte[3:0];
            o_result.marker_flag     = i_view.second_byte[7];
            o_result.payload_type    = i_view.second_byte[6:0];
            o_result.sequence_number = i_view.sequence_word;
            o_result.timestamp       = i_view.timestamp_word;
            o_result.ssrc            = i_view.source_word;
            o_result.payload_offset  = offset[15:0];
        end
    end

endmodule

// File: rtl/rtp_hp_out.sv
// rtp_hp_out: result register with a skid entry, drives the result channel
// depends on rtp_hp_pkg and rtp_hp_out_if
module rtp_hp_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rtp_hp_pkg::t_result i_result,
    output logic                o_space,
    rtp_hp_out_if.source        o_out
);
    import rtp_hp_pkg::*;

    t_result r_main;
    t_result r_skid;
    logic    r_main_valid;
    logic    r_skid_valid;
    logic    pop;

    assign pop     = r_main_valid && o_out.ready;
    assign o_space = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || pop) begin
            r_main_valid <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_valid || pop) begin
            r_main <= r_skid_valid ? r_skid : i_result;
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

    assign o_out.valid           = r_main_valid;
    assign o_out.status          = r_main.status;
    assign o_out.version         = r_main.version;
    assign o_out.padding_flag    = r_main.padding_flag;
    assign o_out.extension_flag  = r_main.extension_flag;
    assign o_out.csrc_count      = r_main.csrc_count;
    assign o_out.marker_flag     = r_main.marker_flag;
    assign o_out.payload_type    = r_main.payload_type;
    assign o_out.sequence_number = r_main.sequence_number;
    assign o_out.timestamp       = r_main.timestamp;
    assign o_out.ssrc            = r_main.ssrc;
    assign o_out.payload_offset  = r_main.payload_offset;

endmodule

// File: rtl/rtp_header_parser.sv
// rtp_header_parser: rtp fixed header parser, one packet byte per item
// input channel i_in: data_byte in arrival order, last_byte flags the final byte
// result channel o_out: one item per packet, given for the final byte only
// carries status (ok, too short, bad version), the header fields and the
// payload offset; fields other than status are zero unless status is ok,
// except version, which is also given with a bad version
// throughput: one byte per cycle while i_in.ready is high, also across packets
// result path: the final byte's result is registered in the result register,
// or in the skid entry while that register still holds an untaken result;
// the checks work combinationally on the header state plus the current byte
// stall: the result register has a skid entry behind it; bytes keep flowing
// while a result waits, and i_in.ready drops only once the skid entry fills
// (a second finished packet while the first is still not taken)
// reset (i_rst_n low, synchronous): byte count and header state cleared,
// both result entries emptied; no clearing pass, ready again straight away
// the byte counter saturates at the maximum packet length; bytes beyond it
// are not captured and the length is taken as the saturated count
module rtp_header_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rtp_hp_in_if.sink     i_in,
    rtp_hp_out_if.source  o_out
);
    import rtp_hp_pkg::*;

    logic    accept;   // byte taken this cycle
    logic    space;    // output side can take one more result
    logic    push;     // final byte taken, result goes out
    t_hdr    view;     // header state including the current byte
    t_result result;

    assign i_in.ready = space;
    assign accept     = i_in.valid && space;
    assign push       = accept && i_in.last_byte;

    // counter and header capture
    rtp_hp_capture u_capture (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .o_view      (view)
    );

    // status decision and payload offset
    rtp_hp_check u_check (
        .i_view   (view),
        .o_result (result)
    );

    // result register plus skid entry
    rtp_hp_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (result),
        .o_space  (space),
        .o_out    (o_out)
    );

endmodule
